>>> sv/merge_sort_engine_assert.svh
// assertion macros for the sort engine, included by merge_sort_engine.sv
`ifndef MERGE_SORT_ENGINE_ASSERT_SVH
`define MERGE_SORT_ENGINE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MSE_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("merge sort engine: assertion failed");

// next-cycle implication, disabled during reset
`define MSE_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("merge sort engine: assertion failed");

`endif

>>> sv/mse_pkg.sv
package mse_pkg;

    // width of the value fields on the ports
    localparam int DATA_BITS = 32;

    // input beat
    typedef struct packed {
        logic signed [DATA_BITS-1:0] value;
        logic                        last_in;
    } in_beat_t;

    // output beat
    typedef struct packed {
        logic signed [DATA_BITS-1:0] sorted_value;
        logic                        last_out;
        logic                        overflow;
    } out_beat_t;

endpackage

>>> sv/mse_cell.sv
module mse_cell #(
    parameter int KEY_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift_en,
    input  logic                ins_valid,
    input  logic [KEY_BITS-1:0] ins_key,
    input  logic                nbr_valid,
    input  logic [KEY_BITS-1:0] nbr_key,
    output logic                held_valid,
    output logic [KEY_BITS-1:0] held_key,
    output logic                pass_valid,
    output logic [KEY_BITS-1:0] pass_key
);
    logic                held_valid_reg, held_valid_next;
    logic [KEY_BITS-1:0] held_key_reg, held_key_next;
    logic                pass_valid_reg, pass_valid_next;
    logic [KEY_BITS-1:0] pass_key_reg, pass_key_next;
    logic                ins_before;

    // strict less-than keeps equal keys in arrival order
    assign ins_before = $signed(ins_key) < $signed(held_key_reg);

    // keep the smaller key, hand the larger one on; shift toward the head when draining
    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_key_next   = held_key_reg;
        pass_valid_next = 1'b0;
        pass_key_next   = pass_key_reg;
        if (shift_en)
        begin
            held_valid_next = nbr_valid;
            held_key_next   = nbr_key;
        end
        else if (ins_valid)
        begin
            if (!held_valid_reg)
            begin
                held_valid_next = 1'b1;
                held_key_next   = ins_key;
            end
            else if (ins_before)
            begin
                held_key_next   = ins_key;
                pass_valid_next = 1'b1;
                pass_key_next   = held_key_reg;
            end
            else
            begin
                pass_valid_next = 1'b1;
                pass_key_next   = ins_key;
            end
        end
    end

    // occupancy flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            pass_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            pass_valid_reg <= pass_valid_next;
        end
    end

    // keys
    always_ff @(posedge clk)
    begin
        held_key_reg <= held_key_next;
        pass_key_reg <= pass_key_next;
    end

    assign held_valid = held_valid_reg;
    assign held_key   = held_key_reg;
    assign pass_valid = pass_valid_reg;
    assign pass_key   = pass_key_reg;

endmodule

>>> sv/merge_sort_engine.sv
// merge_sort_engine: stable ascending sort of a set of signed values
//
// in_valid/in_ready/in_beat carries one value per beat; last_in closes the
// set. A row of MAX_ELEMENTS cells sorts while loading: each cell keeps the
// smaller key and hands the larger one to its neighbor, so equal values keep
// their arrival order. Values past MAX_ELEMENTS are dropped and the run is
// flagged with overflow.
// After the closing beat the row settles, then shifts out toward the head,
// one result per cycle on out_valid/out_ready/out_beat while the receiver
// keeps up, last_out on the final one. Each set passes through loading,
// settling and draining in turn.
// in_ready is low while settling and draining. The result register lets the
// next set start loading while the final result still waits.
// A stalled receiver holds the result register and pauses the drain shift.
// Reset (rst_n, asynchronous, active low) empties the row and returns to
// loading; no result is pending after reset.
module merge_sort_engine #(
    parameter int MAX_ELEMENTS = 64,
    parameter int VALUE_BITS   = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mse_pkg::in_beat_t  in_beat,
    output logic               out_valid,
    input  logic               out_ready,
    output mse_pkg::out_beat_t out_beat
);
    import mse_pkg::*;

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int FL_W  = $clog2(MAX_ELEMENTS);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ELEMENTS);
    localparam logic [FL_W-1:0]  FL_LAST  = FL_W'(MAX_ELEMENTS - 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_FLUSH,
        ST_DRAIN
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    remain_reg, remain_next;
    logic [FL_W-1:0]     flush_reg, flush_next;
    logic                ovf_seen_reg, ovf_seen_next;
    logic                ovf_run_reg, ovf_run_next;
    logic                out_valid_reg, out_valid_next;
    out_beat_t           out_beat_reg, out_beat_next;

    logic                in_accept;
    logic                store_en;
    logic                take;
    logic [CNT_W-1:0]    count_inc;
    logic [VALUE_BITS-1:0] in_key;
    logic [DATA_BITS-1:0]  head_value;

    logic                  held_valid [0:MAX_ELEMENTS-1];
    logic [VALUE_BITS-1:0] held_key   [0:MAX_ELEMENTS-1];
    logic                  pass_valid [0:MAX_ELEMENTS-1];
    logic [VALUE_BITS-1:0] pass_key   [0:MAX_ELEMENTS-1];

    assign in_ready  = (state_reg == ST_LOAD);
    assign in_accept = in_valid && in_ready;
    assign store_en  = in_accept && (count_reg != FULL_CNT);
    assign count_inc = store_en ? count_reg + CNT_W'(1) : count_reg;
    assign take      = (state_reg == ST_DRAIN) && (!out_valid_reg || out_ready);

    // key of the incoming value and port form of the head key
    generate
        if (VALUE_BITS <= DATA_BITS)
        begin : g_narrow
            assign in_key = in_beat.value[VALUE_BITS-1:0];
        end
        else
        begin : g_wide
            assign in_key = {{(VALUE_BITS-DATA_BITS){1'b0}}, in_beat.value};
        end
        if (VALUE_BITS >= DATA_BITS)
        begin : g_out_trunc
            assign head_value = held_key[0][DATA_BITS-1:0];
        end
        else
        begin : g_out_pad
            assign head_value = {{(DATA_BITS-VALUE_BITS){1'b0}}, held_key[0]};
        end
    endgenerate

    // row of sorting cells
    generate
        for (genvar k = 0; k < MAX_ELEMENTS; k++)
        begin : g_cell
            logic                  c_ins_valid;
            logic [VALUE_BITS-1:0] c_ins_key;
            logic                  c_nbr_valid;
            logic [VALUE_BITS-1:0] c_nbr_key;
            if (k == 0)
            begin : g_head
                assign c_ins_valid = store_en;
                assign c_ins_key   = in_key;
            end
            else
            begin : g_body
                assign c_ins_valid = pass_valid[k-1];
                assign c_ins_key   = pass_key[k-1];
            end
            if (k == MAX_ELEMENTS - 1)
            begin : g_tail
                assign c_nbr_valid = 1'b0;
                assign c_nbr_key   = '0;
            end
            else
            begin : g_link
                assign c_nbr_valid = held_valid[k+1];
                assign c_nbr_key   = held_key[k+1];
            end
            mse_cell #(
                .KEY_BITS (VALUE_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift_en   (take),
                .ins_valid  (c_ins_valid),
                .ins_key    (c_ins_key),
                .nbr_valid  (c_nbr_valid),
                .nbr_key    (c_nbr_key),
                .held_valid (held_valid[k]),
                .held_key   (held_key[k]),
                .pass_valid (pass_valid[k]),
                .pass_key   (pass_key[k])
            );
        end
    endgenerate

    // load, settle and drain sequencing
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        flush_next     = flush_reg;
        ovf_seen_next  = ovf_seen_reg;
        ovf_run_next   = ovf_run_reg;
        out_valid_next = out_valid_reg;
        out_beat_next  = out_beat_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_accept)
                begin
                    count_next    = count_inc;
                    ovf_seen_next = ovf_seen_reg || !store_en;
                    if (in_beat.last_in)
                    begin
                        remain_next   = count_inc;
                        ovf_run_next  = ovf_seen_reg || !store_en;
                        count_next    = '0;
                        ovf_seen_next = 1'b0;
                        flush_next    = '0;
                        state_next    = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                flush_next = flush_reg + FL_W'(1);
                if (flush_reg == FL_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (take)
                begin
                    out_valid_next             = 1'b1;
                    out_beat_next.sorted_value = head_value;
                    out_beat_next.last_out     = (remain_reg == CNT_W'(1));
                    out_beat_next.overflow     = ovf_run_reg;
                    remain_next                = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control state and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            remain_reg    <= '0;
            flush_reg     <= '0;
            ovf_seen_reg  <= 1'b0;
            ovf_run_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_beat_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            flush_reg     <= flush_next;
            ovf_seen_reg  <= ovf_seen_next;
            ovf_run_reg   <= ovf_run_next;
            out_valid_reg <= out_valid_next;
            out_beat_reg  <= out_beat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    `include "merge_sort_engine_assert.svh"

    // every drained result comes from an occupied head cell
    `MSE_ASSERT_IMP(a_head_occupied, take, held_valid[0])
    // the last cell never has to hand a key on
    `MSE_ASSERT_IMP(a_tail_no_pass, 1'b1, !pass_valid[MAX_ELEMENTS-1])
    // a closing beat always starts the settle phase
    `MSE_ASSERT_NXT(a_close_flush, in_accept && in_beat.last_in, state_reg == ST_FLUSH)
    // the final result of a run leaves the row empty
    `MSE_ASSERT_NXT(a_drain_empty, take && (remain_reg == CNT_W'(1)), !held_valid[0])

endmodule

>>> bench/merge_sort_engine_test.sv
`timescale 1ns / 100ps

module merge_sort_engine_test;

    import mse_pkg::*;

    localparam int SET_CAPACITY = 64;
    localparam int LONG_HOLD    = 500;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_beat_t  in_beat;
    logic      out_valid;
    logic      out_ready;
    out_beat_t out_beat;

    merge_sort_engine #(
        .MAX_ELEMENTS (SET_CAPACITY),
        .VALUE_BITS   (32)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat)
    );

    // directed stimulus row; want is filled only for single-value sets
    typedef struct {
        logic signed [31:0] value;
        logic               last;
        bit                 typed;
        logic signed [31:0] want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 19;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // single-value sets, result read off directly
        '{32'sh7fffffff, 1'b1, 1'b1, 32'sh7fffffff},
        '{32'sh80000000, 1'b1, 1'b1, 32'sh80000000},
        '{32'sh00000000, 1'b1, 1'b1, 32'sh00000000},
        '{32'shffffffff, 1'b1, 1'b1, 32'shffffffff},
        // mixed extremes with duplicates
        '{32'sh7fffffff, 1'b0, 1'b0, 32'sh0},
        '{32'sh00000000, 1'b0, 1'b0, 32'sh0},
        '{32'sh80000000, 1'b0, 1'b0, 32'sh0},
        '{32'shffffffff, 1'b0, 1'b0, 32'sh0},
        '{32'sh00000001, 1'b0, 1'b0, 32'sh0},
        '{32'sh80000000, 1'b0, 1'b0, 32'sh0},
        '{32'sh7fffffff, 1'b0, 1'b0, 32'sh0},
        '{32'sh00000005, 1'b0, 1'b0, 32'sh0},
        '{32'sh00000005, 1'b0, 1'b0, 32'sh0},
        '{-32'sd5,       1'b1, 1'b0, 32'sh0},
        // descending pair
        '{32'sh00000003, 1'b0, 1'b0, 32'sh0},
        '{-32'sd3,       1'b1, 1'b0, 32'sh0},
        // all equal
        '{32'sh00000009, 1'b0, 1'b0, 32'sh0},
        '{32'sh00000009, 1'b0, 1'b0, 32'sh0},
        '{32'sh00000009, 1'b1, 1'b0, 32'sh0}
    };

    // predictor state: values of the open set and its drop flag
    logic signed [31:0] open_set [$];
    bit                 open_set_dropped;
    out_beat_t          sorted_due [$];

    int  mismatches;
    int  results_seen;
    bit  calm;
    logic signed [31:0] prev_value;

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // absorb one accepted value; on a closing beat emit the sorted run
    task automatic collect_and_sort(input logic signed [31:0] v, input logic close);
        logic signed [31:0] ordered [$];
        out_beat_t          e;
        int                 pos;
        if (open_set.size() < SET_CAPACITY)
            open_set.push_back(v);
        else
            open_set_dropped = 1'b1;
        if (close)
        begin
            // stable insertion: equal values stay in arrival order
            foreach (open_set[i])
            begin
                pos = ordered.size();
                while (pos > 0 && ordered[pos-1] > open_set[i])
                    pos--;
                ordered.insert(pos, open_set[i]);
            end
            foreach (ordered[i])
            begin
                e.sorted_value = ordered[i];
                e.last_out     = (i == ordered.size() - 1);
                e.overflow     = open_set_dropped;
                sorted_due.push_back(e);
            end
            open_set.delete();
            open_set_dropped = 1'b0;
        end
    endtask

    // idle length: mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // random value: extremes, small clustered values, repeats, full range
    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        unique case (r)
            0: return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
            1, 2: return $signed($urandom_range(0, 16)) - 32'sd8;
            3: return prev_value;
            default: return $urandom;
        endcase
    endfunction

    // offer one beat, hold until accepted
    task automatic send_beat(input logic signed [31:0] v, input logic close);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        in_beat.value   <= v;
        in_beat.last_in <= close;
        do
            @(posedge clk);
        while (!in_ready);
        prev_value = v;
    endtask

    // result side: check each beat, random stalls and one long hold-off
    initial
    begin : receiver
        int        hold_left;
        int        len;
        bit        long_done;
        out_beat_t e;
        hold_left = 0;
        long_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (sorted_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: value %0d last %0b overflow %0b",
                                 $signed(out_beat.sorted_value), out_beat.last_out,
                                 out_beat.overflow);
                end
                else
                begin
                    e = sorted_due.pop_front();
                    if (out_beat.sorted_value !== e.sorted_value ||
                        out_beat.last_out !== e.last_out ||
                        out_beat.overflow !== e.overflow)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                                     $signed(e.sorted_value), e.last_out, e.overflow,
                                     $signed(out_beat.sorted_value), out_beat.last_out,
                                     out_beat.overflow);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!long_done && results_seen >= 30)
            begin
                long_done = 1;
                hold_left = LONG_HOLD - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                len = idle_len();
                if (len > 0)
                begin
                    hold_left = len - 1;
                    out_ready <= 1'b0;
                end
                else
                    out_ready <= 1'b1;
            end
        end
    end

    // stimulus and end of run
    initial
    begin : sender
        int random_items;
        int set_idx;
        int set_len;
        int r;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        in_beat          = '0;
        out_ready        = 1'b0;
        mismatches       = 0;
        results_seen     = 0;
        calm             = 1'b0;
        prev_value       = '0;
        open_set_dropped = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[i])
        begin
            send_beat(directed_rows[i].value, directed_rows[i].last);
            if (directed_rows[i].typed)
                sorted_due.push_back(out_beat_t'{directed_rows[i].want, 1'b1, 1'b0});
            else
                collect_and_sort(directed_rows[i].value, directed_rows[i].last);
        end

        // random sets: one exactly full, one overflowing, the rest mostly small
        random_items = 0;
        set_idx      = 0;
        while (random_items < 150)
        begin
            calm = (set_idx % 4 == 3);
            r    = $urandom_range(0, 99);
            if (set_idx == 1)
                set_len = SET_CAPACITY;
            else if (set_idx == 3)
                set_len = $urandom_range(SET_CAPACITY + 1, SET_CAPACITY + 6);
            else if (r < 80)
                set_len = $urandom_range(1, 8);
            else
                set_len = $urandom_range(9, 24);
            for (int k = 0; k < set_len; k++)
            begin
                logic signed [31:0] v;
                v = pick_value();
                send_beat(v, k == set_len - 1);
                collect_and_sort(v, k == set_len - 1);
                random_items++;
            end
            set_idx++;
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // drain
        while (sorted_due.size() != 0)
            @(posedge clk);
        repeat (2 * SET_CAPACITY) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog
    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
